@@ rtl/sdda_pkg.sv @@
// ----------------------------------------------------------------------------
// sdda_pkg
// shared types and constants of the sparse-dense dot and axpy engine
// ----------------------------------------------------------------------------
`default_nettype none

package sdda_pkg;

	localparam int DENSE_DEPTH_DEF   = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int INDEX_W = 10;
	localparam int WORD_W  = 32;
	localparam int ACC_W   = 48;
	localparam int COUNT_W = 16;
	localparam int SIZE_W  = 11;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_DOT   = 2'd2,
		MODE_ADD   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_READ = 2'd0,
		KIND_DOT  = 2'd1,
		KIND_ADD  = 2'd2
	} kind_t;

endpackage

`default_nettype wire

@@ rtl/sparse_dense_dot_and_axpy.sv @@
// ----------------------------------------------------------------------------
// sparse_dense_dot_and_axpy
// dense vector in a one-port-write, one-port-read memory; sparse elements are
// accumulated against it (dot) or scaled and added into it (axpy)
// ----------------------------------------------------------------------------
// an accepted input beat is registered through stages 1, 2 and 3 and then the result register
// throughput: one input beat per cycle while no result beat waits, limited by
// the single memory write port and the dense update read-modify-write in stage 2
// reset: pipeline valids, output valid and vector state clear at once;
// the dense memory is not cleared and holds garbage until written
`default_nettype none

module sparse_dense_dot_and_axpy #(
	parameter int DENSE_DEPTH   = sdda_pkg::DENSE_DEPTH_DEF,
	parameter int FRACTION_BITS = sdda_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire sdda_pkg::mode_t               mode,
	input  wire logic [sdda_pkg::INDEX_W-1:0]  index,
	input  wire logic signed [sdda_pkg::WORD_W-1:0] value,
	input  wire logic signed [sdda_pkg::WORD_W-1:0] scale,
	input  wire logic                          last,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output sdda_pkg::kind_t                    kind,
	output logic signed [sdda_pkg::ACC_W-1:0]  data,
	output logic [sdda_pkg::COUNT_W-1:0]       nonzero_count,
	output logic [sdda_pkg::SIZE_W-1:0]        vector_size,
	output logic                               saturated
);
	import sdda_pkg::*;

	// memory address width and arithmetic widths
	localparam int AW  = (DENSE_DEPTH > 1) ? $clog2(DENSE_DEPTH) : 1;
	// a full product shifted down by the fraction bits
	localparam int PW  = 2 * WORD_W - FRACTION_BITS;
	// dense update sum (product at least a word wide when FRACTION_BITS <= WORD_W)
	localparam int SW  = PW + 1;
	// accumulator sum
	localparam int ASW = ((PW > ACC_W) ? PW : ACC_W) + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic signed [SW-1:0] WORD_HI =
		{{(SW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [SW-1:0] WORD_LO =
		{{(SW-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
	localparam logic signed [ASW-1:0] ACC_HI =
		{{(ASW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [ASW-1:0] ACC_LO =
		{{(ASW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

	// the whole pipe moves together; it stalls only when a result beat waits
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ------------------------------------------------------------------
	// stage 1: item registered, memory read issued at its end,
	// axpy product scale * value formed here
	// ------------------------------------------------------------------
	logic                     v_s1;
	mode_t                    mode_s1;
	logic [INDEX_W-1:0]       index_s1;
	logic [AW-1:0]            addr_s1;
	logic                     inr_s1;
	logic signed [WORD_W-1:0] value_s1;
	logic signed [WORD_W-1:0] scale_s1;
	logic                     last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1  <= mode;
			index_s1 <= index;
			addr_s1  <= AW'(index);
			inr_s1   <= int'(index) < DENSE_DEPTH;
			value_s1 <= value;
			scale_s1 <= scale;
			last_s1  <= last;
		end
	end

	logic signed [2*WORD_W-1:0] axpy_full;
	logic signed [2*WORD_W-1:0] axpy_shift;
	assign axpy_full  = scale_s1 * value_s1;
	// arithmetic shift drops the low bits, rounding toward minus infinity
	assign axpy_shift = axpy_full >>> FRACTION_BITS;

	// ------------------------------------------------------------------
	// stage 2: dense word available; axpy read-modify-write completes
	// here and the dot product value * dense is formed
	// ------------------------------------------------------------------
	logic                     v_s2;
	mode_t                    mode_s2;
	logic [INDEX_W-1:0]       index_s2;
	logic [AW-1:0]            addr_s2;
	logic                     inr_s2;
	logic signed [WORD_W-1:0] value_s2;
	logic signed [PW-1:0]     prod_s2;
	logic                     last_s2;
	logic signed [WORD_W-1:0] rd_s2;

	logic [WORD_W-1:0] dense_mem [DENSE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= mode_s1;
			index_s2 <= index_s1;
			addr_s2  <= addr_s1;
			inr_s2   <= inr_s1;
			value_s2 <= value_s1;
			prod_s2  <= axpy_shift[PW-1:0];
			last_s2  <= last_s1;
		end
	end

	logic                     nz_s2;
	logic signed [SW-1:0]     wsum;
	logic signed [WORD_W-1:0] wclamp;
	logic                     wsat;
	logic                     wr_en;
	logic [WORD_W-1:0]        wr_data;

	assign nz_s2 = value_s2 != '0;
	assign wsum  = $signed({{(SW-WORD_W){rd_s2[WORD_W-1]}}, rd_s2})
		+ $signed({prod_s2[PW-1], prod_s2});

	always_comb begin
		wsat   = 1'b0;
		wclamp = wsum[WORD_W-1:0];
		if (wsum > WORD_HI) begin
			wsat   = 1'b1;
			wclamp = WORD_HI[WORD_W-1:0];
		end else if (wsum < WORD_LO) begin
			wsat   = 1'b1;
			wclamp = WORD_LO[WORD_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = value_s2;
		case (mode_s2)
			MODE_WRITE: begin
				wr_en = v_s2 && inr_s2;
			end
			MODE_ADD: begin
				wr_en   = v_s2 && inr_s2 && nz_s2;
				wr_data = wclamp;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// write in stage 2, read for stage 1; a write to the address being read
	// in the same edge is forwarded so back-to-back updates see each other
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				dense_mem[addr_s2] <= wr_data;
			end
			if (wr_en && addr_s2 == addr_s1) begin
				rd_s2 <= wr_data;
			end else begin
				rd_s2 <= dense_mem[addr_s1];
			end
		end
	end

	// out-of-range entries read as zero
	logic signed [WORD_W-1:0]   dense_eff;
	logic signed [2*WORD_W-1:0] dot_full;
	logic signed [2*WORD_W-1:0] dot_shift;
	assign dense_eff = inr_s2 ? rd_s2 : '0;
	assign dot_full  = value_s2 * dense_eff;
	assign dot_shift = dot_full >>> FRACTION_BITS;

	// ------------------------------------------------------------------
	// stage 3: accumulate, vector bookkeeping, result formed
	// ------------------------------------------------------------------
	logic                     v_s3;
	mode_t                    mode_s3;
	logic [INDEX_W-1:0]       index_s3;
	logic                     nz_s3;
	logic                     last_s3;
	logic                     wsat_s3;
	logic signed [WORD_W-1:0] dense_s3;
	logic signed [PW-1:0]     prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3  <= mode_s2;
			index_s3 <= index_s2;
			nz_s3    <= nz_s2;
			last_s3  <= last_s2;
			wsat_s3  <= wsat && inr_s2;
			dense_s3 <= dense_eff;
			prod_s3  <= dot_shift[PW-1:0];
		end
	end

	// vector state
	logic signed [ACC_W-1:0] acc_q;
	logic [COUNT_W-1:0]      count_q;
	logic [INDEX_W-1:0]      largest_q;
	logic                    any_q;
	logic                    sat_q;

	logic                    is_elem;
	logic                    is_dot;
	logic                    close;
	logic signed [ASW-1:0]   asum;
	logic signed [ACC_W-1:0] aclamp;
	logic                    asat;
	logic signed [ACC_W-1:0] acc_n;
	logic [COUNT_W-1:0]      count_n;
	logic [INDEX_W-1:0]      largest_n;
	logic                    any_n;
	logic                    sat_n;

	assign is_elem = mode_s3 == MODE_DOT || mode_s3 == MODE_ADD;
	assign is_dot  = mode_s3 == MODE_DOT;
	assign close   = is_elem && last_s3;

	assign asum = $signed({{(ASW-ACC_W){acc_q[ACC_W-1]}}, acc_q})
		+ $signed({{(ASW-PW){prod_s3[PW-1]}}, prod_s3});

	always_comb begin
		asat   = 1'b0;
		aclamp = asum[ACC_W-1:0];
		if (asum > ACC_HI) begin
			asat   = 1'b1;
			aclamp = ACC_HI[ACC_W-1:0];
		end else if (asum < ACC_LO) begin
			asat   = 1'b1;
			aclamp = ACC_LO[ACC_W-1:0];
		end
	end

	always_comb begin
		acc_n     = acc_q;
		count_n   = count_q;
		largest_n = largest_q;
		any_n     = any_q;
		sat_n     = sat_q;
		if (nz_s3) begin
			if (count_q != COUNT_MAX) begin
				count_n = count_q + 1'b1;
			end
			if (!any_q || index_s3 > largest_q) begin
				largest_n = index_s3;
			end
			any_n = 1'b1;
			if (is_dot) begin
				acc_n = aclamp;
				sat_n = sat_q | asat;
			end else begin
				sat_n = sat_q | wsat_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			count_q   <= '0;
			largest_q <= '0;
			any_q     <= 1'b0;
			sat_q     <= 1'b0;
		end else if (adv && v_s3 && is_elem) begin
			if (last_s3) begin
				// vector closes: state starts over for the next one
				acc_q     <= '0;
				count_q   <= '0;
				largest_q <= '0;
				any_q     <= 1'b0;
				sat_q     <= 1'b0;
			end else begin
				acc_q     <= acc_n;
				count_q   <= count_n;
				largest_q <= largest_n;
				any_q     <= any_n;
				sat_q     <= sat_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register: holds a beat until the sink takes it
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3 && (mode_s3 == MODE_READ || close);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_s3 == MODE_READ) begin
				kind          <= KIND_READ;
				data          <= ACC_W'(dense_s3);
				nonzero_count <= '0;
				vector_size   <= '0;
				saturated     <= 1'b0;
			end else begin
				kind          <= is_dot ? KIND_DOT : KIND_ADD;
				data          <= is_dot ? acc_n : '0;
				nonzero_count <= count_n;
				vector_size   <= any_n ? SIZE_W'({1'b0, largest_n} + 1'b1) : '0;
				saturated     <= sat_n;
			end
		end
	end

endmodule

`default_nettype wire
